/* hw/rtl/ritoa_pkg.sv */
// shared types and constants for the radix integer to ascii converter
package ritoa_pkg;

    localparam int MAX_DIGITS   = 32;
    localparam int COUNT_W      = 6;
    localparam int POS_W        = 5;
    localparam int RADIX_W      = 5;
    localparam int SIZE_W       = 16;
    localparam int CHAR_W       = 8;
    localparam int NUMBER_W     = 32;
    localparam int DIGIT_W      = 4;
    localparam int BITS_PER_CYC = 8;

    localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
    localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic push_one;
        logic push_digit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;
        logic last_chunk;
        logic quot_zero;
        logic count_full;
        logic fits;
        logic out_free;
        logic last_digit;
    } status_t;

    // uppercase hex glyph for one digit
    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = 8'h30 + {4'h0, d};
        end
        else
        begin
            c = 8'h37 + {4'h0, d};
        end
        return c;
    endfunction

endpackage

/* hw/rtl/radix_integer_to_ascii.sv */
// top level of the unsigned integer to ascii converter, radix 2 to 16
// sequence: a load, byte-wide division steps over the value for each digit, a decision, then
//   one result per cycle while the output is not stalled; a bad radix or zero size skips
//   the division and gives a count-only result
// throughput: one transaction at a time; the input stalls until its last result is pushed
// reset: asynchronous, active low; clears the state machine, counters and output valid
module radix_integer_to_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input transaction
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [ritoa_pkg::NUMBER_W-1:0]      number,
    input  logic [ritoa_pkg::RADIX_W-1:0]       radix,
    input  logic [ritoa_pkg::SIZE_W-1:0]        buffer_size,
    // result transaction
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ritoa_pkg::CHAR_W-1:0]        digit_char,
    output logic [ritoa_pkg::POS_W-1:0]         digit_position,
    output logic                                has_digit,
    output logic [ritoa_pkg::COUNT_W-1:0]       digit_count,
    output logic                                final_item
);

    ritoa_pkg::cmd_t    cmd;
    ritoa_pkg::status_t status;

    // sequencer: load, divide until the quotient is zero or the digit buffer is full, decide, emit
    ritoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // shared divider, digit buffer and output register
    ritoa_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .number         (number),
        .radix          (radix),
        .buffer_size    (buffer_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .digit_char     (digit_char),
        .digit_position (digit_position),
        .has_digit      (has_digit),
        .digit_count    (digit_count),
        .final_item     (final_item)
    );

    // busy right after taking a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accept");

    // a digit sits inside the counted digits
    a_digit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_digit) |-> (digit_count != 6'd0) &&
                                     ({1'b0, digit_position} < digit_count))
        else $error("digit position outside count");

    // the most significant digit closes the transaction's results
    a_final_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && has_digit) |-> (final_item == (digit_position == 5'd0)))
        else $error("final flag does not match position");

    // a count-only result is always the last and carries no character
    a_count_only: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_digit) |-> final_item && (digit_char == 8'd0) &&
                                      (digit_position == 5'd0))
        else $error("malformed count-only result");

endmodule

/* hw/rtl/ritoa_ctrl.sv */
// sequencing state machine for the radix integer to ascii converter
module ritoa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ritoa_pkg::status_t status,
    output ritoa_pkg::cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DIV    = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_ONE    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd.load       = 1'b0;
        cmd.step       = 1'b0;
        cmd.push_one   = 1'b0;
        cmd.push_digit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.bad)
                begin
                    state_next = ST_ONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.last_chunk && (status.quot_zero || status.count_full))
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                state_next = status.fits ? ST_EMIT : ST_ONE;
            end
            ST_ONE:
            begin
                if (status.out_free)
                begin
                    cmd.push_one = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.push_digit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/ritoa_dp.sv */
// divider, digit buffer and output register for the radix integer to ascii converter
module ritoa_dp #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ritoa_pkg::cmd_t                     cmd,
    output ritoa_pkg::status_t                  status,
    input  logic [ritoa_pkg::NUMBER_W-1:0]      number,
    input  logic [ritoa_pkg::RADIX_W-1:0]       radix,
    input  logic [ritoa_pkg::SIZE_W-1:0]        buffer_size,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [ritoa_pkg::CHAR_W-1:0]        digit_char,
    output logic [ritoa_pkg::POS_W-1:0]         digit_position,
    output logic                                has_digit,
    output logic [ritoa_pkg::COUNT_W-1:0]       digit_count,
    output logic                                final_item
);

    // only the low bits of the number take part, at most the port width
    localparam int VW  = (VALUE_BITS < ritoa_pkg::NUMBER_W) ? VALUE_BITS
                                                            : ritoa_pkg::NUMBER_W;
    localparam int NCH = (VW + ritoa_pkg::BITS_PER_CYC - 1) / ritoa_pkg::BITS_PER_CYC;
    localparam int QW  = NCH * ritoa_pkg::BITS_PER_CYC;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int BW  = ritoa_pkg::BITS_PER_CYC;

    logic [QW-1:0]                       sh_reg, sh_next;
    logic [ritoa_pkg::DIGIT_W-1:0]       rem_reg, rem_next;
    logic [CW-1:0]                       chunk_reg, chunk_next;
    logic [ritoa_pkg::COUNT_W-1:0]       count_reg, count_next;
    logic [ritoa_pkg::POS_W-1:0]         idx_reg, idx_next;
    logic [ritoa_pkg::RADIX_W-1:0]       radix_reg;
    logic [ritoa_pkg::SIZE_W-1:0]        size_reg;
    logic [ritoa_pkg::DIGIT_W-1:0]       digit_buf_reg [ritoa_pkg::MAX_DIGITS];

    logic [QW-1:0]                       step_sh;
    logic [ritoa_pkg::DIGIT_W-1:0]       step_rem;
    logic                                last_chunk;

    logic                                out_valid_reg, out_valid_next;
    logic [ritoa_pkg::CHAR_W-1:0]        char_reg;
    logic [ritoa_pkg::POS_W-1:0]         pos_reg;
    logic                                has_reg;
    logic [ritoa_pkg::COUNT_W-1:0]       cnt_reg;
    logic                                fin_reg;
    logic [ritoa_pkg::POS_W-1:0]         emit_pos;

    // eight restoring division steps on the top byte of the shift register
    always_comb
    begin
        logic [BW-1:0]                     top;
        logic [BW-1:0]                     q;
        logic [ritoa_pkg::DIGIT_W-1:0]     r;
        logic [ritoa_pkg::RADIX_W-1:0]     t;
        top = sh_reg[QW-1 -: BW];
        q   = '0;
        r   = rem_reg;
        for (int i = BW - 1; i >= 0; i--)
        begin
            t = {r, top[i]};
            if (t >= radix_reg)
            begin
                q[i] = 1'b1;
                t    = t - radix_reg;
            end
            r = t[ritoa_pkg::DIGIT_W-1:0];
        end
        step_sh  = (sh_reg << BW) | QW'(q);
        step_rem = r;
    end

    assign last_chunk = (chunk_reg == CW'(NCH - 1));
    assign emit_pos   = ritoa_pkg::POS_W'(count_reg - 6'd1 - {1'b0, idx_reg});

    assign status.bad        = (radix_reg < ritoa_pkg::MIN_RADIX) ||
                               (radix_reg > ritoa_pkg::MAX_RADIX) ||
                               (size_reg == '0);
    assign status.last_chunk = last_chunk;
    assign status.quot_zero  = (step_sh == '0);
    assign status.count_full = (count_reg == ritoa_pkg::COUNT_W'(ritoa_pkg::MAX_DIGITS - 1));
    assign status.fits       = ({10'd0, count_reg} < size_reg);
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.last_digit = (emit_pos == '0);

    always_comb
    begin
        sh_next    = sh_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            sh_next    = QW'(number[VW-1:0]);
            rem_next   = '0;
            chunk_next = '0;
            count_next = '0;
            idx_next   = '0;
        end
        else if (cmd.step)
        begin
            sh_next = step_sh;
            if (last_chunk)
            begin
                rem_next   = '0;
                chunk_next = '0;
                count_next = count_reg + 6'd1;
            end
            else
            begin
                rem_next   = step_rem;
                chunk_next = chunk_reg + 1'b1;
            end
        end
        else if (cmd.push_digit)
        begin
            idx_next = idx_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            chunk_reg <= chunk_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        if (cmd.load)
        begin
            radix_reg <= radix;
            size_reg  <= buffer_size;
        end
        if (cmd.step && last_chunk)
        begin
            digit_buf_reg[count_reg[ritoa_pkg::POS_W-1:0]] <= step_rem;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push_one || cmd.push_digit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_one)
        begin
            char_reg <= '0;
            pos_reg  <= '0;
            has_reg  <= 1'b0;
            cnt_reg  <= count_reg;
            fin_reg  <= 1'b1;
        end
        else if (cmd.push_digit)
        begin
            char_reg <= ritoa_pkg::glyph(digit_buf_reg[idx_reg]);
            pos_reg  <= emit_pos;
            has_reg  <= 1'b1;
            cnt_reg  <= count_reg;
            fin_reg  <= (emit_pos == '0);
        end
    end

    assign out_valid      = out_valid_reg;
    assign digit_char     = char_reg;
    assign digit_position = pos_reg;
    assign has_digit      = has_reg;
    assign digit_count    = cnt_reg;
    assign final_item     = fin_reg;

endmodule
